>>> rtl/core/clamped_slew_limited_view_follow_macros.svh
// assertion macros for the view follow block
`ifndef CLAMPED_SLEW_LIMITED_VIEW_FOLLOW_MACROS_SVH
`define CLAMPED_SLEW_LIMITED_VIEW_FOLLOW_MACROS_SVH
`ifndef SYNTHESIS
`define CSLVF_ASSERT_SAME(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("cslvf assertion failed");
`define CSLVF_ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("cslvf assertion failed");
`else
`define CSLVF_ASSERT_SAME(name, cond, prop)
`define CSLVF_ASSERT_NEXT(name, cond, prop)
`endif
`endif

>>> rtl/core/cslvf_pkg.sv
// shared constants, types and codes for the view follow block
package cslvf_pkg;

    localparam int TILE_SHIFT = 10;
    localparam int TILE_W     = 10;
    localparam int VIEW_W     = 16;
    localparam int TGT_IN_W   = 21;
    localparam int CTR_W      = 20;
    localparam int EDGE_W     = 21;
    localparam int CFG_IDX_W  = 2;

    // level extent in units, then the widest |distance| on one axis
    localparam int LVL_W = TILE_W + TILE_SHIFT;
    localparam int A_W   = (LVL_W > CTR_W) ? LVL_W : CTR_W;
    localparam int TGT_W = ((LVL_W > TGT_IN_W) ? LVL_W : TGT_IN_W) + 2;
    localparam int MUL_W = A_W + 8;
    localparam int ACC_W = 2 * MUL_W + 2;
    localparam int Q_W   = 8;
    localparam int BIT_W = 3;

    localparam logic [CTR_W-1:0] CENTER_MAX = {CTR_W{1'b1}};
    localparam logic [ACC_W-1:0] SNAP_SQ    = ACC_W'(160 * 160);
    localparam logic [ACC_W-1:0] STEP_UNITS = ACC_W'(240);

    localparam logic [CTR_W-1:0]  CENTER_X_RST = CTR_W'(15360);
    localparam logic [CTR_W-1:0]  CENTER_Y_RST = CTR_W'(16640);
    localparam logic [VIEW_W-1:0] VIEW_W_RST   = VIEW_W'(30720);
    localparam logic [VIEW_W-1:0] VIEW_H_RST   = VIEW_W'(17280);
    localparam logic [TILE_W-1:0] LVL_W_RST    = TILE_W'(30);
    localparam logic [TILE_W-1:0] LVL_H_RST    = TILE_W'(17);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_W     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_H     = 2'd3;

    // item kinds
    localparam logic KIND_TICK     = 1'b0;
    localparam logic KIND_TELEPORT = 1'b1;

    // shared unit operations
    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_MUL = 1'b1;

    typedef struct packed {
        logic [VIEW_W-1:0] view_width;
        logic [VIEW_W-1:0] view_height;
        logic [TILE_W-1:0] level_width_tiles;
        logic [TILE_W-1:0] level_height_tiles;
    } cfg_t;

    typedef struct packed {
        logic             op;
        logic [ACC_W-1:0] a;
        logic [ACC_W-1:0] b;
        logic [ACC_W-1:0] lim;
    } alu_req_t;

    typedef struct packed {
        logic [ACC_W-1:0] val;
        logic             le;
    } alu_rsp_t;

endpackage

>>> rtl/core/cslvf_if.sv
// handshake channels for tick items and view results
interface cslvf_req_if import cslvf_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic                       target_present;
    logic signed [TGT_IN_W-1:0] target_x;
    logic signed [TGT_IN_W-1:0] target_y;

    modport source (output valid, kind, target_present, target_x, target_y, input ready);
    modport sink (input valid, kind, target_present, target_x, target_y, output ready);
endinterface

interface cslvf_rsp_if import cslvf_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic        [CTR_W-1:0]  center_x;
    logic        [CTR_W-1:0]  center_y;
    logic signed [EDGE_W-1:0] left_edge;
    logic signed [EDGE_W-1:0] top_edge;

    modport source (output valid, center_x, center_y, left_edge, top_edge, input ready);
    modport sink (input valid, center_x, center_y, left_edge, top_edge, output ready);
endinterface

>>> rtl/core/cslvf_alu.sv
// shared multiply / add-and-compare unit
module cslvf_alu import cslvf_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [2*MUL_W-1:0] prod;
    logic [ACC_W-1:0]   res;

    assign prod = req.a[MUL_W-1:0] * req.b[MUL_W-1:0];

    always_comb
    begin
        case (req.op)
            ALU_MUL: res = ACC_W'(prod);
            ALU_ADD: res = req.a + req.b;
            default: res = req.a + req.b;
        endcase
    end

    assign rsp.val = res;
    assign rsp.le  = (res <= req.lim);

endmodule

>>> rtl/core/cslvf_seq.sv
// sequencer: clamp, distance test and bitwise step search on the shared unit
`include "clamped_slew_limited_view_follow_macros.svh"

module cslvf_seq import cslvf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    cslvf_req_if.sink     req,
    cslvf_rsp_if.source   rsp,
    output alu_req_t      alu_req,
    input  alu_rsp_t      alu_rsp
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLAMP = 4'd1;
    localparam logic [3:0] ST_DIFF  = 4'd2;
    localparam logic [3:0] ST_SQX   = 4'd3;
    localparam logic [3:0] ST_SQY   = 4'd4;
    localparam logic [3:0] ST_SUM   = 4'd5;
    localparam logic [3:0] ST_SCL   = 4'd6;
    localparam logic [3:0] ST_RHS   = 4'd7;
    localparam logic [3:0] ST_B0    = 4'd8;
    localparam logic [3:0] ST_B1    = 4'd9;
    localparam logic [3:0] ST_B2    = 4'd10;
    localparam logic [3:0] ST_APPLY = 4'd11;
    localparam logic [3:0] ST_DONE  = 4'd12;

    localparam int DW = A_W + 2;
    localparam int NW = CTR_W + 2;

    function automatic logic [A_W-1:0] clamp_axis(
        input logic signed [TGT_IN_W-1:0] t,
        input logic [VIEW_W-1:0]          vsize,
        input logic [TILE_W-1:0]          tiles
    );
        logic signed [TGT_W-1:0] te;
        logic signed [TGT_W-1:0] half;
        logic signed [TGT_W-1:0] hi;
        logic signed [TGT_W-1:0] r;
        te   = TGT_W'(t);
        half = $signed({{(TGT_W-VIEW_W+1){1'b0}}, vsize[VIEW_W-1:1]});
        hi   = $signed({{(TGT_W-LVL_W){1'b0}}, tiles, {TILE_SHIFT{1'b0}}}) - half;
        r    = (te > hi) ? hi : te;
        // lower bound wins when the level is smaller than the view
        r    = (r < half) ? half : r;
        return r[A_W-1:0];
    endfunction

    function automatic logic [CTR_W-1:0] sat_jump(input logic [A_W-1:0] t);
        return (t > A_W'(CENTER_MAX)) ? CENTER_MAX : t[CTR_W-1:0];
    endfunction

    logic [3:0]                 state_reg, state_next;
    logic                       kind_reg, kind_next;
    logic                       pres_reg, pres_next;
    logic signed [TGT_IN_W-1:0] rx_reg, rx_next;
    logic signed [TGT_IN_W-1:0] ry_reg, ry_next;
    logic [A_W-1:0]             tx_reg, tx_next;
    logic [A_W-1:0]             ty_reg, ty_next;
    logic [A_W-1:0]             ax_reg, ax_next;
    logic [A_W-1:0]             ay_reg, ay_next;
    logic                       sx_reg, sx_next;
    logic                       sy_reg, sy_next;
    logic [ACC_W-1:0]           d2_reg, d2_next;
    logic [ACC_W-1:0]           m_reg, m_next;
    logic [ACC_W-1:0]           r_reg, r_next;
    logic [ACC_W-1:0]           s_reg, s_next;
    logic [ACC_W-1:0]           p_reg, p_next;
    logic [ACC_W-1:0]           x_reg, x_next;
    logic [Q_W-1:0]             q_reg, q_next;
    logic [BIT_W-1:0]           bit_reg, bit_next;
    logic                       axis_reg, axis_next;
    logic [CTR_W-1:0]           cx_reg, cx_next;
    logic [CTR_W-1:0]           cy_reg, cy_next;
    logic                       snap_reg, snap_next;
    logic                       ov_reg, ov_next;
    logic [CTR_W-1:0]           ocx_reg, ocx_next;
    logic [CTR_W-1:0]           ocy_reg, ocy_next;
    logic [EDGE_W-1:0]          ole_reg, ole_next;
    logic [EDGE_W-1:0]          ote_reg, ote_next;

    logic                       accept;
    logic signed [DW-1:0]       dx, dy;
    logic [A_W-1:0]             a_sel;
    logic                       neg_sel;
    logic [CTR_W-1:0]           cur_sel;
    logic signed [NW-1:0]       moved;
    logic [CTR_W-1:0]           moved_sat;
    logic [ACC_W-1:0]           d2_sh2;
    logic [ACC_W-1:0]           d2_sh1;
    logic [ACC_W-1:0]           p_sh;
    logic [NW-1:0]              left_full;
    logic [NW-1:0]              top_full;
    logic                       out_free;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign out_free  = !ov_reg || rsp.ready;

    assign dx = $signed({2'b00, tx_reg}) - $signed({{(DW-CTR_W){1'b0}}, cx_reg});
    assign dy = $signed({2'b00, ty_reg}) - $signed({{(DW-CTR_W){1'b0}}, cy_reg});

    assign a_sel   = axis_reg ? ay_reg : ax_reg;
    assign neg_sel = axis_reg ? sy_reg : sx_reg;
    assign cur_sel = axis_reg ? cy_reg : cx_reg;

    // incremental square: (q + 2^b)^2 d2 = q^2 d2 + 2^(b+1) q d2 + 2^(2b) d2
    assign d2_sh2 = d2_reg << {bit_reg, 1'b0};
    assign d2_sh1 = d2_reg << bit_reg;
    assign p_sh   = p_reg << ({1'b0, bit_reg} + 4'd1);

    assign moved = neg_sel
        ? $signed({2'b00, cur_sel}) - $signed({{(NW-Q_W){1'b0}}, q_reg})
        : $signed({2'b00, cur_sel}) + $signed({{(NW-Q_W){1'b0}}, q_reg});

    always_comb
    begin
        if (moved < 0)
            moved_sat = '0;
        else if (moved > $signed({2'b00, CENTER_MAX}))
            moved_sat = CENTER_MAX;
        else
            moved_sat = moved[CTR_W-1:0];
    end

    assign left_full = {2'b00, cx_reg} - {{(NW-VIEW_W+1){1'b0}}, cfg.view_width[VIEW_W-1:1]};
    assign top_full  = {2'b00, cy_reg} - {{(NW-VIEW_W+1){1'b0}}, cfg.view_height[VIEW_W-1:1]};

    always_comb
    begin
        alu_req.op  = ALU_ADD;
        alu_req.a   = '0;
        alu_req.b   = '0;
        alu_req.lim = r_reg;
        case (state_reg)
            ST_SQX:
            begin
                alu_req.op = ALU_MUL;
                alu_req.a  = ACC_W'(ax_reg);
                alu_req.b  = ACC_W'(ax_reg);
            end
            ST_SQY:
            begin
                alu_req.op = ALU_MUL;
                alu_req.a  = ACC_W'(ay_reg);
                alu_req.b  = ACC_W'(ay_reg);
            end
            ST_SUM:
            begin
                alu_req.a   = d2_reg;
                alu_req.b   = m_reg;
                alu_req.lim = SNAP_SQ;
            end
            ST_SCL:
            begin
                alu_req.op = ALU_MUL;
                alu_req.a  = ACC_W'(a_sel);
                alu_req.b  = STEP_UNITS;
            end
            ST_RHS:
            begin
                alu_req.op = ALU_MUL;
                alu_req.a  = m_reg;
                alu_req.b  = m_reg;
            end
            ST_B0:
            begin
                alu_req.a = s_reg;
                alu_req.b = d2_sh2;
            end
            ST_B1:
            begin
                alu_req.a = x_reg;
                alu_req.b = p_sh;
            end
            ST_B2:
            begin
                alu_req.a = p_reg;
                alu_req.b = d2_sh1;
            end
            default:
            begin
                alu_req.op = ALU_ADD;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        pres_next  = pres_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        tx_next    = tx_reg;
        ty_next    = ty_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        d2_next    = d2_reg;
        m_next     = m_reg;
        r_next     = r_reg;
        s_next     = s_reg;
        p_next     = p_reg;
        x_next     = x_reg;
        q_next     = q_reg;
        bit_next   = bit_reg;
        axis_next  = axis_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        snap_next  = snap_reg;
        ov_next    = ov_reg && !rsp.ready;
        ocx_next   = ocx_reg;
        ocy_next   = ocy_reg;
        ole_next   = ole_reg;
        ote_next   = ote_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next = req.kind;
                    pres_next = req.target_present;
                    rx_next   = req.target_x;
                    ry_next   = req.target_y;
                    if (req.kind == KIND_TELEPORT)
                    begin
                        snap_next  = 1'b1;
                        state_next = ST_DONE;
                    end
                    else if (!req.target_present)
                        state_next = ST_DONE;
                    else
                        state_next = ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                tx_next    = clamp_axis(rx_reg, cfg.view_width, cfg.level_width_tiles);
                ty_next    = clamp_axis(ry_reg, cfg.view_height, cfg.level_height_tiles);
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                sx_next    = dx[DW-1];
                sy_next    = dy[DW-1];
                ax_next    = dx[DW-1] ? A_W'(-dx) : A_W'(dx);
                ay_next    = dy[DW-1] ? A_W'(-dy) : A_W'(dy);
                state_next = ST_SQX;
            end
            ST_SQX:
            begin
                d2_next    = alu_rsp.val;
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                m_next     = alu_rsp.val;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                d2_next = alu_rsp.val;
                if (snap_reg || alu_rsp.le)
                begin
                    cx_next    = sat_jump(tx_reg);
                    cy_next    = sat_jump(ty_reg);
                    snap_next  = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    axis_next  = 1'b0;
                    state_next = ST_SCL;
                end
            end
            ST_SCL:
            begin
                m_next     = alu_rsp.val;
                state_next = ST_RHS;
            end
            ST_RHS:
            begin
                r_next     = alu_rsp.val;
                s_next     = '0;
                p_next     = '0;
                q_next     = '0;
                bit_next   = '1;
                state_next = ST_B0;
            end
            ST_B0:
            begin
                x_next     = alu_rsp.val;
                state_next = ST_B1;
            end
            ST_B1:
            begin
                if (alu_rsp.le)
                begin
                    s_next          = alu_rsp.val;
                    q_next[bit_reg] = 1'b1;
                    state_next      = ST_B2;
                end
                else if (bit_reg == '0)
                    state_next = ST_APPLY;
                else
                begin
                    bit_next   = bit_reg - 1'b1;
                    state_next = ST_B0;
                end
            end
            ST_B2:
            begin
                p_next = alu_rsp.val;
                if (bit_reg == '0)
                    state_next = ST_APPLY;
                else
                begin
                    bit_next   = bit_reg - 1'b1;
                    state_next = ST_B0;
                end
            end
            ST_APPLY:
            begin
                if (axis_reg)
                begin
                    cy_next    = moved_sat;
                    state_next = ST_DONE;
                end
                else
                begin
                    cx_next    = moved_sat;
                    axis_next  = 1'b1;
                    state_next = ST_SCL;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ocx_next   = cx_reg;
                    ocy_next   = cy_reg;
                    ole_next   = left_full[EDGE_W-1:0];
                    ote_next   = top_full[EDGE_W-1:0];
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= 1'b0;
            cx_reg    <= CENTER_X_RST;
            cy_reg    <= CENTER_Y_RST;
            snap_reg  <= 1'b1;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            snap_reg  <= snap_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        pres_reg <= pres_next;
        rx_reg   <= rx_next;
        ry_reg   <= ry_next;
        tx_reg   <= tx_next;
        ty_reg   <= ty_next;
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        d2_reg   <= d2_next;
        m_reg    <= m_next;
        r_reg    <= r_next;
        s_reg    <= s_next;
        p_reg    <= p_next;
        x_reg    <= x_next;
        q_reg    <= q_next;
        bit_reg  <= bit_next;
        ocx_reg  <= ocx_next;
        ocy_reg  <= ocy_next;
        ole_reg  <= ole_next;
        ote_reg  <= ote_next;
    end

    assign rsp.valid     = ov_reg;
    assign rsp.center_x  = ocx_reg;
    assign rsp.center_y  = ocy_reg;
    assign rsp.left_edge = $signed(ole_reg);
    assign rsp.top_edge  = $signed(ote_reg);

    `CSLVF_ASSERT_NEXT(a_busy_after_accept, accept, state_reg != ST_IDLE)
    `CSLVF_ASSERT_SAME(a_step_bounded, state_reg == ST_APPLY, ACC_W'(q_reg) <= STEP_UNITS)
    `CSLVF_ASSERT_SAME(a_search_under_limit, state_reg == ST_B0, s_reg <= r_reg)
    `CSLVF_ASSERT_SAME(a_result_from_done, $rose(ov_reg), $past(state_reg) == ST_DONE)
    `CSLVF_ASSERT_NEXT(a_done_waits, state_reg == ST_DONE && !out_free, state_reg == ST_DONE)

endmodule

>>> rtl/core/clamped_slew_limited_view_follow.sv
// top level: config registers, sequencer and shared arithmetic unit
//
//   port     dir    handshake          payload
//   req      sink   valid / ready      kind, target_present, target_x, target_y
//   rsp      source valid / ready      center_x, center_y, left_edge, top_edge
//   cfg_*    write  cfg_wr_en          cfg_index, cfg_data
//
// teleport or absent-target items: idle, then done, which waits for a free result
// register; jump to the target: clamp, difference, squares, snap test; rate-limited
// move: also the 8-bit step search per axis on the shared multiply / add unit
// req.ready is high only while the sequencer is idle; one result register buffers rsp
// reset is asynchronous and needs no clearing pass
module clamped_slew_limited_view_follow import cslvf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    cslvf_req_if.sink            req,
    cslvf_rsp_if.source          rsp,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VIEW_W-1:0]    cfg_data
);

    cfg_t     cfg_reg, cfg_next;
    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_VIEW_WIDTH:  cfg_next.view_width         = cfg_data;
                REG_VIEW_HEIGHT: cfg_next.view_height        = cfg_data;
                REG_LEVEL_W:     cfg_next.level_width_tiles  = cfg_data[TILE_W-1:0];
                REG_LEVEL_H:     cfg_next.level_height_tiles = cfg_data[TILE_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.view_width         <= VIEW_W_RST;
            cfg_reg.view_height        <= VIEW_H_RST;
            cfg_reg.level_width_tiles  <= LVL_W_RST;
            cfg_reg.level_height_tiles <= LVL_H_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    cslvf_seq u_seq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .req     (req),
        .rsp     (rsp),
        .alu_req (alu_req),
        .alu_rsp (alu_rsp)
    );

    cslvf_alu u_alu
    (
        .req (alu_req),
        .rsp (alu_rsp)
    );

endmodule

>>> bench/view_follow_checker.sv
// result checker for the view follow block: mirrors its state and compares every result beat
`timescale 1ns / 100ps
module view_follow_checker import cslvf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    cslvf_req_if                 req,
    cslvf_rsp_if                 rsp,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VIEW_W-1:0]    cfg_data,
    output int                   fail_count,
    output int                   outstanding
);

    localparam longint SNAP_RADIUS = 160;
    localparam longint STEP_LEN    = 240;
    localparam longint CENTER_TOP  = (longint'(1) << CTR_W) - 1;

    typedef struct packed {
        logic        [CTR_W-1:0]  center_x;
        logic        [CTR_W-1:0]  center_y;
        logic signed [EDGE_W-1:0] left_edge;
        logic signed [EDGE_W-1:0] top_edge;
    } view_t;

    logic [VIEW_W-1:0] view_w;
    logic [VIEW_W-1:0] view_h;
    logic [TILE_W-1:0] tiles_w;
    logic [TILE_W-1:0] tiles_h;
    longint            ctr_x;
    longint            ctr_y;
    bit                snap_armed;
    view_t             expected_views[$];

    // lower bound applied last, so it wins when the level is smaller than the view
    function automatic longint clamp_to_level(longint t, logic [VIEW_W-1:0] size,
                                              logic [TILE_W-1:0] tiles);
        longint half;
        longint upper;
        half  = longint'(size >> 1);
        upper = (longint'(tiles) << TILE_SHIFT) - half;
        if (t > upper)
            t = upper;
        if (t < half)
            t = half;
        return t;
    endfunction

    function automatic longint saturate_center(longint v);
        if (v < 0)
            return 0;
        if (v > CENTER_TOP)
            return CENTER_TOP;
        return v;
    endfunction

    // largest q <= 240 with q * |d| ... i.e. q * sqrt(d2) <= 240 * |d|, exact in integers
    function automatic longint slew_step(longint d, longint d2);
        longint unsigned mag;
        longint unsigned rhs;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        mag = (d < 0) ? -d : d;
        rhs = mag * mag * STEP_LEN * STEP_LEN;
        lo  = 0;
        hi  = STEP_LEN;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid * longint'(d2) <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return (d < 0) ? -longint'(lo) : longint'(lo);
    endfunction

    function automatic view_t follow_target(logic kind, logic present,
                                            logic signed [TGT_IN_W-1:0] tx_in,
                                            logic signed [TGT_IN_W-1:0] ty_in);
        longint tx;
        longint ty;
        longint dx;
        longint dy;
        longint d2;
        view_t  v;
        if (kind == KIND_TELEPORT)
            snap_armed = 1'b1;
        else if (present)
        begin
            tx = clamp_to_level(longint'(tx_in), view_w, tiles_w);
            ty = clamp_to_level(longint'(ty_in), view_h, tiles_h);
            dx = tx - ctr_x;
            dy = ty - ctr_y;
            d2 = dx * dx + dy * dy;
            if (snap_armed || d2 <= SNAP_RADIUS * SNAP_RADIUS)
            begin
                ctr_x      = saturate_center(tx);
                ctr_y      = saturate_center(ty);
                snap_armed = 1'b0;
            end
            else
            begin
                ctr_x = saturate_center(ctr_x + slew_step(dx, d2));
                ctr_y = saturate_center(ctr_y + slew_step(dy, d2));
            end
        end
        v.center_x  = CTR_W'(ctr_x);
        v.center_y  = CTR_W'(ctr_y);
        v.left_edge = EDGE_W'(ctr_x - longint'(view_w >> 1));
        v.top_edge  = EDGE_W'(ctr_y - longint'(view_h >> 1));
        return v;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic compare_result();
        view_t want;
        if (expected_views.size() == 0)
        begin
            $display("%0t: result beat with nothing expected, got center (%0d,%0d) edges (%0d,%0d)",
                     $time, rsp.center_x, rsp.center_y, rsp.left_edge, rsp.top_edge);
            fail_count++;
        end
        else
        begin
            want = expected_views.pop_front();
            check_field("center_x", want.center_x, rsp.center_x);
            check_field("center_y", want.center_y, rsp.center_y);
            check_field("left_edge", want.left_edge, rsp.left_edge);
            check_field("top_edge", want.top_edge, rsp.top_edge);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_w      = VIEW_W_RST;
            view_h      = VIEW_H_RST;
            tiles_w     = LVL_W_RST;
            tiles_h     = LVL_H_RST;
            ctr_x       = longint'(CENTER_X_RST);
            ctr_y       = longint'(CENTER_Y_RST);
            snap_armed  = 1'b1;
            fail_count  = 0;
            expected_views.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_VIEW_WIDTH:  view_w  = cfg_data;
                    REG_VIEW_HEIGHT: view_h  = cfg_data;
                    REG_LEVEL_W:     tiles_w = cfg_data[TILE_W-1:0];
                    REG_LEVEL_H:     tiles_h = cfg_data[TILE_W-1:0];
                    default: ;
                endcase
            end
            // retire first so a result can never match the beat accepted at the same edge
            if (rsp.valid && rsp.ready)
                compare_result();
            if (req.valid && req.ready)
                expected_views.push_back(follow_target(req.kind, req.target_present,
                                                       req.target_x, req.target_y));
            outstanding <= expected_views.size();
        end
    end

endmodule

>>> bench/tb_clamped_slew_limited_view_follow.sv
// testbench top for the view follow block: stimulus, config phases and verdict
`timescale 1ns / 100ps
module tb_clamped_slew_limited_view_follow;
    import cslvf_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [VIEW_W-1:0]    cfg_data;
    int                   fail_count;
    int                   outstanding;

    bit quiet;
    int beats_sent;
    int settings_done;
    int walk_x;
    int walk_y;
    int span_x;
    int span_y;

    cslvf_req_if req_ch();
    cslvf_rsp_if rsp_ch();

    clamped_slew_limited_view_follow dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    view_follow_checker checker_i
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // mostly short gaps, a few long ones, none at all during quiet stretches
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int any_coord();
        return int'($urandom_range(0, 2097151)) - 1048576;
    endfunction

    // target drifts slowly so the center chases it, with an occasional jump across the level
    function automatic int wander(int pos, int span);
        if ($urandom_range(0, 19) == 0)
            pos = $urandom_range(0, span);
        else
            pos = pos + int'($urandom_range(0, 800)) - 400;
        if (pos < -1048576)
            pos = -1048576;
        if (pos > 1048575)
            pos = 1048575;
        return pos;
    endfunction

    initial
    begin
        int stall;
        rsp_ch.ready = 1'b0;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall = idle_len();
            end
        end
    end

    task automatic drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_beat(input logic kind, input logic present, input int x, input int y);
        int gap;
        gap = idle_len();
        // now and then hold off until every result is back
        if ($urandom_range(0, 49) == 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            do @(posedge clk); while (outstanding != 0);
        end
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.kind           <= kind;
        req_ch.target_present <= present;
        req_ch.target_x       <= TGT_IN_W'(x);
        req_ch.target_y       <= TGT_IN_W'(y);
        do @(posedge clk); while (!req_ch.ready);
        beats_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= VIEW_W'(value);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_view(input int vw, input int vh, input int lw, input int lh);
        drain();
        write_reg(REG_VIEW_WIDTH, vw);
        write_reg(REG_VIEW_HEIGHT, vh);
        write_reg(REG_LEVEL_W, lw);
        write_reg(REG_LEVEL_H, lh);
        span_x = int'(TILE_W'(lw)) << TILE_SHIFT;
        span_y = int'(TILE_W'(lh)) << TILE_SHIFT;
        walk_x = span_x / 2;
        walk_y = span_y / 2;
        settings_done++;
    endtask

    task automatic run_random(input int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            quiet = (i >= 20 && i < 50);
            r = $urandom_range(0, 99);
            if (r < 8)
                send_beat(KIND_TELEPORT, 1'($urandom_range(0, 1)), any_coord(), any_coord());
            else if (r < 16)
                send_beat(KIND_TICK, 1'b0, any_coord(), any_coord());
            else if (r < 26)
                send_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          any_coord(), any_coord());
            else
            begin
                walk_x = wander(walk_x, span_x);
                walk_y = wander(walk_y, span_y);
                send_beat(KIND_TICK, 1'b1, walk_x, walk_y);
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        req_ch.valid          = 1'b0;
        req_ch.kind           = KIND_TICK;
        req_ch.target_present = 1'b0;
        req_ch.target_x       = '0;
        req_ch.target_y       = '0;
        cfg_wr_en             = 1'b0;
        cfg_index             = REG_VIEW_WIDTH;
        cfg_data              = '0;
        rst_n                 = 1'b0;
        quiet                 = 1'b0;
        beats_sent            = 0;
        settings_done         = 1;
        span_x                = 30 << TILE_SHIFT;
        span_y                = 17 << TILE_SHIFT;
        walk_x                = span_x / 2;
        walk_y                = span_y / 2;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // reset config: first tick snaps, field extremes, teleport, absent target
        send_beat(KIND_TICK, 1'b1, 1048575, -1048576);
        send_beat(KIND_TICK, 1'b1, -1048576, 1048575);
        send_beat(KIND_TELEPORT, 1'b0, 0, 0);
        send_beat(KIND_TICK, 1'b0, 5000, 5000);

        // wide level: snap, inside snap radius, exactly on it, just past it, moves
        set_view(30720, 17280, 1023, 1023);
        send_beat(KIND_TELEPORT, 1'b1, 0, 0);
        send_beat(KIND_TICK, 1'b1, 100000, 100000);
        send_beat(KIND_TICK, 1'b1, 100100, 100050);
        send_beat(KIND_TICK, 1'b1, 100260, 100050);
        send_beat(KIND_TICK, 1'b1, 100421, 100050);
        send_beat(KIND_TICK, 1'b1, 300000, 250000);
        send_beat(KIND_TICK, 1'b1, 300000, 250000);
        send_beat(KIND_TICK, 1'b1, -1048576, 250000);
        send_beat(KIND_TICK, 1'b0, 1048575, 1048575);
        send_beat(KIND_TELEPORT, 1'b1, -5, -5);
        send_beat(KIND_TICK, 1'b1, 1048575, 1048575);
        send_beat(KIND_TICK, 1'b1, -1048576, -1048576);

        // odd view sizes with a zero-width level
        set_view(31, 33, 0, 1);
        send_beat(KIND_TICK, 1'b1, 500, 500);
        send_beat(KIND_TICK, 1'b1, -1048576, 1048575);
        send_beat(KIND_TELEPORT, 1'b1, 1048575, -1048576);
        send_beat(KIND_TICK, 1'b1, 0, 0);

        set_view(30720, 17280, 200, 120);
        run_random(300);
        set_view(16, 16, 1023, 1023);
        run_random(100);
        // view larger than the level: lower bound wins
        set_view(65535, 65535, 1, 1);
        run_random(60);
        set_view(0, 1, 0, 1023);
        run_random(60);
        repeat (4)
        begin
            set_view($urandom_range(16, 65535), $urandom_range(16, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 65535));
            run_random(80);
        end

        drain();
        repeat (70) @(posedge clk);
        $display("covered %0d beats over %0d register settings: snaps, rate-limited moves,",
                 beats_sent, settings_done);
        $display("teleports, absent targets, odd and zero view sizes and level clamp extremes");
        if (fail_count == 0 && outstanding == 0)
            $display("tb_clamped_slew_limited_view_follow: done, clean");
        else
            $display("tb_clamped_slew_limited_view_follow: done, errors");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d results still expected", outstanding);
        $display("tb_clamped_slew_limited_view_follow: done, errors");
        $finish;
    end

endmodule
